// File: rtl/core/dsm_pkg.sv
`timescale 1ns / 1ps
package dsm_pkg;

  localparam int FracBits = 14;
  localparam int DirW     = 16;
  localparam int WgtW     = 15;
  localparam int WgtReset = 164;
  localparam int One      = 1 << FracBits;

  // length stage: sq on raw components, L = isqrt(sq << LenShift)
  localparam int SqW      = 2 * DirW;
  localparam int LenShift = 24;
  localparam int LenW     = (SqW + LenShift) / 2;
  localparam int NumShift = FracBits + LenShift / 2;
  localparam int NumW     = DirW + NumShift;
  localparam int QW       = FracBits + 1;

  // frame stage: magnitudes of the unit vector
  localparam int NW       = FracBits + 1;
  localparam int PW       = 2 * NW;
  localparam int DW       = PW / 2;
  localparam int CNumW    = 2 * FracBits + 1;

  // shape stage
  localparam int ProdW    = 2 * DirW;
  localparam int RndW     = ProdW - FracBits + 1;

  localparam int Latency  = (LenW + QW + 3) + (DW + QW + 4) + 3;

  localparam int PairI [0:5] = '{0, 0, 0, 1, 1, 2};
  localparam int PairJ [0:5] = '{0, 1, 2, 1, 2, 2};

  localparam logic signed [RndW-1:0] SatHi = 32767;
  localparam logic signed [RndW-1:0] SatLo = -32768;

  typedef enum logic [1:0] {
    PrimPoint  = 2'd0,
    PrimLine   = 2'd1,
    PrimPlane  = 2'd2,
    PrimSurfel = 2'd3
  } prim_e;

  typedef logic signed [DirW-1:0] fix_t;

  typedef struct packed {
    prim_e prim;
    fix_t  raw_x, raw_y, raw_z;
  } item_t;

  typedef struct packed {
    item_t item;
    fix_t  n_x, n_y, n_z;
  } ndat_t;

  typedef struct packed {
    logic  valid;
    ndat_t data;
  } norm_t;

  typedef struct packed {
    ndat_t           nd;
    logic [DW-1:0]   d;
    fix_t            c1_x, c1_y, c2_x, c2_y;
  } fdat_t;

  typedef struct packed {
    logic  valid;
    fdat_t data;
  } frame_t;

  typedef struct packed {
    logic valid;
    fix_t m_xx, m_xy, m_xz, m_yy, m_yz, m_zz;
    fix_t norm_x, norm_y, norm_z;
  } res_t;

  function automatic logic [DirW-1:0] mag16(fix_t v);
    return v[DirW-1] ? DirW'(-v) : DirW'(v);
  endfunction

  function automatic fix_t apply_sign(logic neg, logic [QW-1:0] m);
    fix_t r;
    r = fix_t'({1'b0, m});
    return neg ? -r : r;
  endfunction

  // shift right by FracBits, rounding half away from zero
  function automatic logic signed [RndW-1:0] shr_rnd(logic signed [ProdW-1:0] v);
    logic [ProdW-1:0]           m;
    logic [ProdW-1:0]           s;
    logic signed [RndW-1:0]     r;
    m = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
    s = (m + (ProdW'(1) << (FracBits - 1))) >> FracBits;
    r = $signed({1'b0, s[RndW-2:0]});
    return v[ProdW-1] ? -r : r;
  endfunction

  function automatic fix_t sat16(logic signed [RndW-1:0] v);
    fix_t r;
    if (v > SatHi) begin
      r = fix_t'(SatHi);
    end else if (v < SatLo) begin
      r = fix_t'(SatLo);
    end else begin
      r = fix_t'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/dsm_norm.sv
`timescale 1ns / 1ps
module dsm_norm import dsm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output norm_t norm_o
);

  logic [DirW-1:0] ax, ay, az;
  logic [SqW-1:0]  sq_d;

  assign ax   = mag16(item_i.raw_x);
  assign ay   = mag16(item_i.raw_y);
  assign az   = mag16(item_i.raw_z);
  assign sq_d = SqW'(ax) * SqW'(ax) + SqW'(ay) * SqW'(ay) + SqW'(az) * SqW'(az);

  // square root, one result bit per stage
  logic              sv_q   [0:LenW];
  item_t             sit_q  [0:LenW];
  logic [2*LenW-1:0] rad_q  [0:LenW];
  logic [LenW:0]     rem_q  [0:LenW];
  logic [LenW-1:0]   root_q [0:LenW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sit_q[0]  <= item_i;
    rad_q[0]  <= {sq_d, {LenShift{1'b0}}};
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar k = 0; k < LenW; k++) begin : g_sqrt
    logic [LenW+1:0] cur, trial;
    logic            take;
    assign cur   = {rem_q[k][LenW-1:0], rad_q[k][2*LenW-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sit_q[k+1]  <= sit_q[k];
      rad_q[k+1]  <= rad_q[k] << 2;
      rem_q[k+1]  <= take ? (LenW+1)'(cur - trial) : (LenW+1)'(cur);
      root_q[k+1] <= {root_q[k][LenW-2:0], take};
    end
  end

  // three restoring dividers sharing the length as divisor
  logic            dv_q   [0:QW];
  item_t           dit_q  [0:QW];
  logic [LenW-1:0] dl_q   [0:QW];
  logic [NumW-1:0] drem_q [0:QW][0:2];
  logic [QW-1:0]   dq_q   [0:QW][0:2];
  fix_t            rin    [0:2];
  fix_t            rout   [0:2];

  assign rin[0]  = sit_q[LenW].raw_x;
  assign rin[1]  = sit_q[LenW].raw_y;
  assign rin[2]  = sit_q[LenW].raw_z;
  assign rout[0] = dit_q[QW].raw_x;
  assign rout[1] = dit_q[QW].raw_y;
  assign rout[2] = dit_q[QW].raw_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= sv_q[LenW];
    end
  end

  always_ff @(posedge clk_i) begin
    dit_q[0] <= sit_q[LenW];
    dl_q[0]  <= root_q[LenW];
  end

  for (genvar c = 0; c < 3; c++) begin : g_num
    logic [NumW-1:0] num;
    assign num = {mag16(rin[c]), {NumShift{1'b0}}} + NumW'(root_q[LenW] >> 1);
    always_ff @(posedge clk_i) begin
      drem_q[0][c] <= num;
      dq_q[0][c]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [NumW-1:0] dsh;
    assign dsh = {{(NumW-LenW){1'b0}}, dl_q[j]} << (QW - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dit_q[j+1] <= dit_q[j];
      dl_q[j+1]  <= dl_q[j];
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic take;
      assign take = drem_q[j][c] >= dsh;
      always_ff @(posedge clk_i) begin
        drem_q[j+1][c] <= take ? drem_q[j][c] - dsh : drem_q[j][c];
        dq_q[j+1][c]   <= {dq_q[j][c][QW-2:0], take};
      end
    end
  end

  // sign, clamp and zero-length case
  fix_t  nv [0:2];
  logic  out_v_q;
  ndat_t out_q;

  for (genvar c = 0; c < 3; c++) begin : g_out
    logic [QW-1:0] qc;
    assign qc    = (dq_q[QW][c] > QW'(One)) ? QW'(One) : dq_q[QW][c];
    assign nv[c] = (dl_q[QW] == '0) ? '0 : apply_sign(rout[c][DirW-1], qc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.item <= dit_q[QW];
    out_q.n_x  <= nv[0];
    out_q.n_y  <= nv[1];
    out_q.n_z  <= nv[2];
  end

  assign norm_o = '{valid: out_v_q, data: out_q};

endmodule

// File: rtl/core/dsm_frame.sv
`timescale 1ns / 1ps
module dsm_frame import dsm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  norm_t  norm_i,
  output frame_t frame_o
);

  logic [NW-1:0]    mx, my, mz;
  logic [PW-1:0]    p_d;
  logic [CNumW-1:0] xz_d, yz_d;

  assign mx   = NW'(mag16(norm_i.data.n_x));
  assign my   = NW'(mag16(norm_i.data.n_y));
  assign mz   = NW'(mag16(norm_i.data.n_z));
  assign p_d  = PW'(mx) * PW'(mx) + PW'(my) * PW'(my);
  assign xz_d = CNumW'(mx) * CNumW'(mz);
  assign yz_d = CNumW'(my) * CNumW'(mz);

  // planar length square root
  logic             fv_q   [0:DW];
  ndat_t            fd_q   [0:DW];
  logic [PW-1:0]    rad_q  [0:DW];
  logic [DW:0]      rem_q  [0:DW];
  logic [DW-1:0]    root_q [0:DW];
  logic [CNumW-1:0] xz_q   [0:DW];
  logic [CNumW-1:0] yz_q   [0:DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q[0] <= 1'b0;
    end else begin
      fv_q[0] <= norm_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fd_q[0]   <= norm_i.data;
    rad_q[0]  <= p_d;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    xz_q[0]   <= xz_d;
    yz_q[0]   <= yz_d;
  end

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    logic [DW+1:0] cur, trial;
    logic          take;
    assign cur   = {rem_q[k][DW-1:0], rad_q[k][PW-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[k+1] <= 1'b0;
      end else begin
        fv_q[k+1] <= fv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      fd_q[k+1]   <= fd_q[k];
      rad_q[k+1]  <= rad_q[k] << 2;
      rem_q[k+1]  <= take ? (DW+1)'(cur - trial) : (DW+1)'(cur);
      root_q[k+1] <= {root_q[k][DW-2:0], take};
      xz_q[k+1]   <= xz_q[k];
      yz_q[k+1]   <= yz_q[k];
    end
  end

  // round to nearest and clamp
  logic [DW:0]      dp;
  logic [DW-1:0]    dcl;
  logic             gv_q;
  ndat_t            gd_q;
  logic [DW-1:0]    gdd_q;
  logic [CNumW-1:0] gxz_q, gyz_q;

  assign dp  = {1'b0, root_q[DW]} + (DW+1)'(rem_q[DW] > {1'b0, root_q[DW]});
  assign dcl = (dp > (DW+1)'(One)) ? DW'(One) : dp[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
    end else begin
      gv_q <= fv_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    gd_q  <= fd_q[DW];
    gdd_q <= dcl;
    gxz_q <= xz_q[DW];
    gyz_q <= yz_q[DW];
  end

  // four dividers by d with saturation; lanes: c1_x, c1_y, c2_x, c2_y
  logic [CNumW-1:0] nums [0:3];
  logic             cv_q   [0:QW];
  ndat_t            cd_q   [0:QW];
  logic [DW-1:0]    cdd_q  [0:QW];
  logic [CNumW-1:0] crem_q [0:QW][0:3];
  logic [QW-1:0]    cq_q   [0:QW][0:3];
  logic             cov_q  [0:QW][0:3];

  assign nums[0] = {NW'(mag16(gd_q.n_y)), {FracBits{1'b0}}};
  assign nums[1] = {NW'(mag16(gd_q.n_x)), {FracBits{1'b0}}};
  assign nums[2] = gxz_q;
  assign nums[3] = gyz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= gv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cd_q[0]  <= gd_q;
    cdd_q[0] <= gdd_q;
  end

  for (genvar c = 0; c < 4; c++) begin : g_num
    logic [CNumW-1:0] numr;
    assign numr = nums[c] + CNumW'(gdd_q >> 1);
    always_ff @(posedge clk_i) begin
      crem_q[0][c] <= numr;
      cq_q[0][c]   <= '0;
      cov_q[0][c]  <= {1'b0, numr} >= {gdd_q, {QW{1'b0}}};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [CNumW-1:0] dsh;
    assign dsh = {{(CNumW-DW){1'b0}}, cdd_q[j]} << (QW - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[j+1] <= 1'b0;
      end else begin
        cv_q[j+1] <= cv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      cd_q[j+1]  <= cd_q[j];
      cdd_q[j+1] <= cdd_q[j];
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
      logic take;
      assign take = crem_q[j][c] >= dsh;
      always_ff @(posedge clk_i) begin
        crem_q[j+1][c] <= take ? crem_q[j][c] - dsh : crem_q[j][c];
        cq_q[j+1][c]   <= {cq_q[j][c][QW-2:0], take};
        cov_q[j+1][c]  <= cov_q[j][c];
      end
    end
  end

  ndat_t ne;
  logic  neg [0:3];
  fix_t  cv  [0:3];

  assign ne     = cd_q[QW];
  assign neg[0] = ne.n_y[DirW-1];
  assign neg[1] = !ne.n_x[DirW-1] && (ne.n_x != '0);
  assign neg[2] = ne.n_x[DirW-1] ^ ne.n_z[DirW-1];
  assign neg[3] = ne.n_y[DirW-1] ^ ne.n_z[DirW-1];

  for (genvar c = 0; c < 4; c++) begin : g_out
    logic [QW-1:0] qc;
    assign qc    = (cov_q[QW][c] || cq_q[QW][c] > QW'(One)) ? QW'(One) : cq_q[QW][c];
    assign cv[c] = apply_sign(neg[c], qc);
  end

  logic  out_v_q;
  fdat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= cv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.nd   <= ne;
    out_q.d    <= cdd_q[QW];
    out_q.c1_x <= cv[0];
    out_q.c1_y <= cv[1];
    out_q.c2_x <= cv[2];
    out_q.c2_y <= cv[3];
  end

  assign frame_o = '{valid: out_v_q, data: out_q};

endmodule

// File: rtl/core/dsm_shape.sv
`timescale 1ns / 1ps
module dsm_shape import dsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  frame_t          frame_i,
  input  logic [WgtW-1:0] weight_i,
  output res_t            res_o
);

  // columns of R, identity when the planar length is zero
  fix_t  col [0:2][0:2];
  fdat_t fi;
  logic  dzero;

  assign fi    = frame_i.data;
  assign dzero = (fi.d == '0);

  always_comb begin
    if (dzero) begin
      col[0][0] = fix_t'(One); col[0][1] = '0;          col[0][2] = '0;
      col[1][0] = '0;          col[1][1] = fix_t'(One); col[1][2] = '0;
      col[2][0] = '0;          col[2][1] = '0;          col[2][2] = fix_t'(One);
    end else begin
      col[0][0] = fi.nd.n_x;   col[0][1] = fi.nd.n_y;   col[0][2] = fi.nd.n_z;
      col[1][0] = fi.c1_x;     col[1][1] = fi.c1_y;     col[1][2] = '0;
      col[2][0] = fi.c2_x;     col[2][1] = fi.c2_y;     col[2][2] = -fix_t'({1'b0, fi.d});
    end
  end

  logic  t_v_q;
  ndat_t t_d_q;
  fix_t  t_q [0:2][0:5];

  for (genvar k = 0; k < 3; k++) begin : g_col
    for (genvar e = 0; e < 6; e++) begin : g_ent
      logic signed [ProdW-1:0] pr;
      assign pr = ProdW'(col[k][PairI[e]]) * ProdW'(col[k][PairJ[e]]);
      always_ff @(posedge clk_i) begin
        t_q[k][e] <= fix_t'(shr_rnd(pr));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else begin
      t_v_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    t_d_q <= fi.nd;
  end

  // scale by the diagonal of S
  logic [DirW-1:0]         s [0:2];
  logic                    p_v_q;
  ndat_t                   p_d_q;
  logic signed [ProdW-1:0] p_q [0:2][0:5];

  always_comb begin
    case (t_d_q.item.prim)
      PrimLine: begin
        s[0] = '0;          s[1] = DirW'(One);    s[2] = DirW'(One);
      end
      PrimPlane: begin
        s[0] = DirW'(One);  s[1] = '0;            s[2] = '0;
      end
      default: begin
        s[0] = DirW'(One);  s[1] = DirW'(weight_i); s[2] = DirW'(weight_i);
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_scale
    for (genvar e = 0; e < 6; e++) begin : g_ent
      always_ff @(posedge clk_i) begin
        p_q[k][e] <= ProdW'($signed({1'b0, s[k]})) * ProdW'(t_q[k][e]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_d_q <= t_d_q;
  end

  // sum, round and saturate; a point gives the identity and its raw direction
  fix_t m [0:5];
  logic is_point;

  assign is_point = (p_d_q.item.prim == PrimPoint);

  for (genvar e = 0; e < 6; e++) begin : g_sum
    logic signed [ProdW-1:0] acc;
    assign acc  = p_q[0][e] + p_q[1][e] + p_q[2][e];
    assign m[e] = is_point ? ((PairI[e] == PairJ[e]) ? fix_t'(One) : '0)
                           : sat16(shr_rnd(acc));
  end

  logic o_v_q;
  res_t o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q.valid  <= 1'b1;
    o_q.m_xx   <= m[0];
    o_q.m_xy   <= m[1];
    o_q.m_xz   <= m[2];
    o_q.m_yy   <= m[3];
    o_q.m_yz   <= m[4];
    o_q.m_zz   <= m[5];
    o_q.norm_x <= is_point ? p_d_q.item.raw_x : p_d_q.n_x;
    o_q.norm_y <= is_point ? p_d_q.item.raw_y : p_d_q.n_y;
    o_q.norm_z <= is_point ? p_d_q.item.raw_z : p_d_q.n_z;
  end

  always_comb begin
    res_o       = o_q;
    res_o.valid = o_v_q;
  end

endmodule

// File: rtl/core/direction_shape_matrix_core.sv
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------------
// command   | primitive_type_i, dir_x_i, dir_y_i, dir_z_i  | start_i while busy_o low
// result    | m_*_o, norm_*_o                              | done_o, one cycle
// config    | cfg_wdata_i (surfel tangent weight)          | cfg_we_i, no wait
//
// One transaction may start every cycle; busy_o stays low.
// Each result passes through 28 square-root and 15 divide stages plus 3
// registers for the unit vector, 15 + 15 stages plus 4 registers for
// the frame, and 3 registers for the matrix.
// Reset clears the valid bits only; the weight resets to 164.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module direction_shape_matrix_core import dsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            cfg_we_i,
  input  logic [WgtW-1:0] cfg_wdata_i,
  input  logic [1:0]      primitive_type_i,
  input  fix_t            dir_x_i,
  input  fix_t            dir_y_i,
  input  fix_t            dir_z_i,
  output logic            done_o,
  output fix_t            m_xx_o,
  output fix_t            m_xy_o,
  output fix_t            m_xz_o,
  output fix_t            m_yy_o,
  output fix_t            m_yz_o,
  output fix_t            m_zz_o,
  output fix_t            norm_x_o,
  output fix_t            norm_y_o,
  output fix_t            norm_z_o
);

  logic [WgtW-1:0] weight_q;
  logic            accept;
  item_t           item;
  norm_t           norm;
  frame_t          frame;
  res_t            res;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign item   = '{prim: prim_e'(primitive_type_i), raw_x: dir_x_i, raw_y: dir_y_i,
                    raw_z: dir_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WgtW'(WgtReset);
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  dsm_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item),
    .norm_o  (norm)
  );

  dsm_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .norm_i  (norm),
    .frame_o (frame)
  );

  dsm_shape u_shape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame),
    .weight_i (weight_q),
    .res_o    (res)
  );

  assign done_o   = res.valid;
  assign m_xx_o   = res.m_xx;
  assign m_xy_o   = res.m_xy;
  assign m_xz_o   = res.m_xz;
  assign m_yy_o   = res.m_yy;
  assign m_yz_o   = res.m_yz;
  assign m_zz_o   = res.m_zz;
  assign norm_x_o = res.norm_x;
  assign norm_y_o = res.norm_y;
  assign norm_z_o = res.norm_z;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted transaction produced no result");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without a matching transaction");

endmodule
